// ===== sv/ffba_pkg.sv =====
// Shared types and constants for the first-fit byte arena allocator.
package ffba_pkg;

    localparam int ARENA_BYTES = 128;
    localparam int ADDR_W      = 7;
    localparam int POS_W       = 9;
    localparam int SIZE_W      = 7;
    localparam int BYTE_W      = 8;
    localparam int HDR_BYTES   = 3;
    localparam logic [POS_W-1:0] SCAN_END = POS_W'(ARENA_BYTES - HDR_BYTES);

    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_WRITE = 2'd2,
        MODE_READ  = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LD_RD,
        ST_LD_SH,
        ST_TEST,
        ST_WIN_RD,
        ST_WIN_SH,
        ST_END,
        ST_WR0,
        ST_WR1,
        ST_WR2,
        ST_RD,
        ST_RD_WAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   wa;
        logic [BYTE_W-1:0]   wd;
        logic                re;
        logic [POS_W-1:0]    ra;
        logic                shift;
    } t_cmd;

    typedef struct packed {
        logic                live;
        logic [BYTE_W-1:0]   win_size;
        logic [BYTE_W-1:0]   rd_data;
    } t_status;

endpackage

// ===== sv/ffba_datapath.sv =====
// Arena memory, its valid bits and the three-byte header window.
module ffba_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ffba_pkg::t_cmd    i_cmd,
    output ffba_pkg::t_status o_status
);

    logic [ffba_pkg::BYTE_W-1:0] r_mem [ffba_pkg::ARENA_BYTES];
    logic [ffba_pkg::ARENA_BYTES-1:0] r_valid;
    logic [ffba_pkg::BYTE_W-1:0] r_rd;
    logic [ffba_pkg::BYTE_W-1:0] r_w0, r_w1, r_w2;
    logic                        in_range;

    assign in_range = (i_cmd.ra < ffba_pkg::POS_W'(ffba_pkg::ARENA_BYTES));

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.wa] <= i_cmd.wd;
        end
        if (i_cmd.re) begin
            if (in_range && r_valid[i_cmd.ra[ffba_pkg::ADDR_W-1:0]]) begin
                r_rd <= r_mem[i_cmd.ra[ffba_pkg::ADDR_W-1:0]];
            end else begin
                r_rd <= '0;
            end
        end
        if (i_cmd.shift) begin
            r_w0 <= r_w1;
            r_w1 <= r_w2;
            r_w2 <= r_rd;
        end
    end

    // Entries not written since reset read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.we) begin
            r_valid[i_cmd.wa] <= 1'b1;
        end
    end

    assign o_status.live = (r_w0 == ffba_pkg::BYTE_W'(1)) && (r_w1 != '0) &&
                           ({1'b0, r_w2} == {1'b0, r_w1} + 9'd1);
    assign o_status.win_size = r_w1;
    assign o_status.rd_data  = r_rd;

endmodule

// ===== sv/ffba_ctrl.sv =====
// Sequencer for allocate, free, write and read transactions.
module ffba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [23:0]       i_s_tdata,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [15:0]       o_m_tdata,
    output ffba_pkg::t_cmd    o_cmd,
    input  ffba_pkg::t_status i_status
);

    ffba_pkg::t_state r_state, n_state;
    logic [ffba_pkg::POS_W-1:0]  r_pos, n_pos, r_k, n_k;
    logic [1:0]                  r_cnt, n_cnt;
    logic [ffba_pkg::SIZE_W-1:0] r_n;
    logic [ffba_pkg::ADDR_W-1:0] r_addr;
    logic [1:0]                  r_mode;
    logic                        r_grant, n_grant;
    logic                        r_ovld;
    logic [15:0]                 r_odata, n_odata;
    logic                        accept, load_out, win_done, fits;
    logic [ffba_pkg::POS_W-1:0]  win_end;

    assign accept   = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == ffba_pkg::ST_IDLE);
    assign load_out = (r_state == ffba_pkg::ST_OUT) && (!r_ovld || i_m_tready);
    assign win_end  = r_pos + ffba_pkg::POS_W'(r_n) + ffba_pkg::POS_W'(ffba_pkg::HDR_BYTES);
    assign win_done = (r_k + 9'd1 == win_end);
    assign fits     = (r_pos < ffba_pkg::SCAN_END) &&
                      (r_pos + ffba_pkg::POS_W'(r_n) <= ffba_pkg::SCAN_END);

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_k     = r_k;
        n_cnt   = r_cnt;
        n_grant = r_grant;
        unique case (r_state)
            ffba_pkg::ST_IDLE: begin
                if (accept) begin
                    n_grant = 1'b0;
                    n_pos   = '0;
                    unique case (ffba_pkg::t_mode'(i_s_tdata[1:0]))
                        ffba_pkg::MODE_ALLOC: n_state = ffba_pkg::ST_SCAN;
                        ffba_pkg::MODE_READ:  n_state = ffba_pkg::ST_RD;
                        default:              n_state = ffba_pkg::ST_OUT;
                    endcase
                end
            end
            ffba_pkg::ST_SCAN: begin
                n_k   = r_pos;
                n_cnt = '0;
                n_state = (r_pos < ffba_pkg::SCAN_END) ? ffba_pkg::ST_LD_RD
                                                       : ffba_pkg::ST_END;
            end
            ffba_pkg::ST_LD_RD: n_state = ffba_pkg::ST_LD_SH;
            ffba_pkg::ST_LD_SH: begin
                if (r_cnt == 2'd2) begin
                    n_state = ffba_pkg::ST_TEST;
                end else begin
                    n_cnt   = r_cnt + 2'd1;
                    n_state = ffba_pkg::ST_LD_RD;
                end
            end
            ffba_pkg::ST_TEST: begin
                if (i_status.live) begin
                    // A live header at the scan point is skipped whole.
                    if (r_k == r_pos) begin
                        n_pos = r_pos + {1'b0, i_status.win_size} +
                                ffba_pkg::POS_W'(ffba_pkg::HDR_BYTES);
                    end else begin
                        n_pos = r_pos + 9'd1;
                    end
                    n_state = ffba_pkg::ST_SCAN;
                end else if (win_done) begin
                    n_state = ffba_pkg::ST_END;
                end else begin
                    n_state = ffba_pkg::ST_WIN_RD;
                end
            end
            ffba_pkg::ST_WIN_RD: n_state = ffba_pkg::ST_WIN_SH;
            ffba_pkg::ST_WIN_SH: begin
                n_k     = r_k + 9'd1;
                n_state = ffba_pkg::ST_TEST;
            end
            ffba_pkg::ST_END: begin
                n_grant = fits;
                n_state = fits ? ffba_pkg::ST_WR0 : ffba_pkg::ST_OUT;
            end
            ffba_pkg::ST_WR0:    n_state = ffba_pkg::ST_WR1;
            ffba_pkg::ST_WR1:    n_state = ffba_pkg::ST_WR2;
            ffba_pkg::ST_WR2:    n_state = ffba_pkg::ST_OUT;
            ffba_pkg::ST_RD:     n_state = ffba_pkg::ST_RD_WAIT;
            ffba_pkg::ST_RD_WAIT: n_state = ffba_pkg::ST_OUT;
            ffba_pkg::ST_OUT: begin
                if (load_out) begin
                    n_state = ffba_pkg::ST_IDLE;
                end
            end
            default: n_state = ffba_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state) inside
            ffba_pkg::ST_IDLE: begin
                if (accept) begin
                    if (ffba_pkg::t_mode'(i_s_tdata[1:0]) == ffba_pkg::MODE_FREE &&
                        i_s_tdata[15:9] >= 7'd3) begin
                        o_cmd.we = 1'b1;
                        o_cmd.wa = i_s_tdata[15:9] - 7'd3;
                    end
                    if (ffba_pkg::t_mode'(i_s_tdata[1:0]) == ffba_pkg::MODE_WRITE) begin
                        o_cmd.we = 1'b1;
                        o_cmd.wa = i_s_tdata[15:9];
                        o_cmd.wd = i_s_tdata[23:16];
                    end
                end
            end
            ffba_pkg::ST_LD_RD: begin
                o_cmd.re = 1'b1;
                o_cmd.ra = r_k + {7'd0, r_cnt};
            end
            ffba_pkg::ST_WIN_RD: begin
                o_cmd.re = 1'b1;
                o_cmd.ra = r_k + ffba_pkg::POS_W'(ffba_pkg::HDR_BYTES);
            end
            ffba_pkg::ST_LD_SH, ffba_pkg::ST_WIN_SH: o_cmd.shift = 1'b1;
            ffba_pkg::ST_WR0: begin
                o_cmd.we = 1'b1;
                o_cmd.wa = r_pos[ffba_pkg::ADDR_W-1:0];
                o_cmd.wd = ffba_pkg::BYTE_W'(1);
            end
            ffba_pkg::ST_WR1: begin
                o_cmd.we = 1'b1;
                o_cmd.wa = r_pos[ffba_pkg::ADDR_W-1:0] + 7'd1;
                o_cmd.wd = {1'b0, r_n};
            end
            ffba_pkg::ST_WR2: begin
                o_cmd.we = 1'b1;
                o_cmd.wa = r_pos[ffba_pkg::ADDR_W-1:0] + 7'd2;
                o_cmd.wd = {1'b0, r_n} + 8'd1;
            end
            ffba_pkg::ST_RD: begin
                o_cmd.re = 1'b1;
                o_cmd.ra = {2'b00, r_addr};
            end
            default: o_cmd = '0;
        endcase
    end

    // Result word: block address and grant flag for allocate, byte for read.
    always_comb begin
        n_odata = '0;
        if (r_grant) begin
            n_odata[6:0] = r_pos[ffba_pkg::ADDR_W-1:0] + 7'd3;
            n_odata[7]   = 1'b1;
        end
        if (ffba_pkg::t_mode'(r_mode) == ffba_pkg::MODE_READ) begin
            n_odata[15:8] = i_status.rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffba_pkg::ST_IDLE;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_ovld <= 1'b1;
            end else if (i_m_tready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_k     <= n_k;
        r_cnt   <= n_cnt;
        r_grant <= n_grant;
        if (accept) begin
            r_mode <= i_s_tdata[1:0];
            r_n    <= i_s_tdata[8:2];
            r_addr <= i_s_tdata[15:9];
        end
        if (load_out) begin
            r_odata <= n_odata;
        end
    end

    assign o_m_tvalid = r_ovld;
    assign o_m_tdata  = r_odata;

endmodule

// ===== sv/first_fit_byte_arena_allocator_top.sv =====
// Top level of the first-fit byte arena allocator.
//
//  Channel  Direction  Payload
//  s_axis   in         tdata = mode[1:0], size[8:2], address[15:9], data[23:16]
//  m_axis   out        tdata = block_address[6:0], granted[7], read_byte[15:8]
//
// One result transaction follows every input transaction, one item at a time.
// Free and write go straight to the result; read passes through a memory read and
// a wait state. An allocate spends a setup state and load steps that fill the
// header window per scan position, then a test for each window byte and a memory
// read and shift before each further test, so its time per position grows with
// the window length, quadratic in the arena size at worst. A grant adds three
// header writes. Reset clears the arena through per-byte valid bits at once, so
// no clearing pass is needed. A waiting result is held in the output register
// until taken; the next input is taken once that result is loaded.
module first_fit_byte_arena_allocator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // mode, size, address, data (low bit up)
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // block_address, granted, read_byte
);

    ffba_pkg::t_cmd    cmd;
    ffba_pkg::t_status status;

    // The controller sequences each transaction and owns the result register.
    ffba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    // The datapath holds the arena and recognises header patterns.
    ffba_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status)
    );

endmodule
